// ===== hw/rtl/ggu_pkg.sv =====
// package: shared constants, state encoding and controller/datapath interface types
package ggu_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int THR_BITS    = FRAC_BITS + 1;
  localparam int VOL_BITS    = 31;
  localparam int GRAD_BITS   = 17;
  localparam int CNT_BITS    = 6;
  localparam int MUL_STEPS   = 9;
  localparam int SCALE_STEPS = 31;
  localparam int NORM_STEPS  = 16;
  localparam int SQRT_STEPS  = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_PREV_X, S_PREV_Y, S_STORE, S_LAST_X, S_LAST_Y, S_DIV_X, S_DIV_Y,
    S_SQ_X, S_SQ_Y, S_SQRT, S_NORM_X, S_NORM_Y, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_FACE_PX, OP_FACE_PY, OP_FACE_LX, OP_FACE_LY, OP_DIV_X, OP_DIV_Y,
    OP_SQ_X, OP_SQ_Y, OP_SQRT, OP_NORM_X, OP_NORM_Y
  } op_t;

  typedef struct packed {
    logic take;
    logic cell_start;
    logic store_prev;
    logic start;
    logic finish;
    op_t  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic norm;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/ggu_ctrl.sv =====
// controller: sequences face accumulation and the per-cell back end
module ggu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  ggu_pkg::status_t status,
  output ggu_pkg::cmd_t    cmd
);

  ggu_pkg::state_t state, state_next;
  logic in_cell, launched, last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ggu_pkg::S_IDLE;
      in_cell  <= 1'b0;
      launched <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= (state_next == state) && (state != ggu_pkg::S_IDLE);
      if (state == ggu_pkg::S_IDLE && in_valid) begin
        in_cell <= 1'b1;
        last_r  <= in_last;
      end
      if (state == ggu_pkg::S_STORE && last_r) in_cell <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ggu_pkg::S_IDLE:
        if (in_valid) state_next = in_cell ? ggu_pkg::S_PREV_X : ggu_pkg::S_STORE;
      ggu_pkg::S_PREV_X: if (launched && status.done) state_next = ggu_pkg::S_PREV_Y;
      ggu_pkg::S_PREV_Y: if (launched && status.done) state_next = ggu_pkg::S_STORE;
      ggu_pkg::S_STORE:  state_next = last_r ? ggu_pkg::S_LAST_X : ggu_pkg::S_IDLE;
      ggu_pkg::S_LAST_X: if (launched && status.done) state_next = ggu_pkg::S_LAST_Y;
      ggu_pkg::S_LAST_Y: if (launched && status.done) state_next = ggu_pkg::S_DIV_X;
      ggu_pkg::S_DIV_X:  if (launched && status.done) state_next = ggu_pkg::S_DIV_Y;
      ggu_pkg::S_DIV_Y:  if (launched && status.done) state_next = ggu_pkg::S_SQ_X;
      ggu_pkg::S_SQ_X:   if (launched && status.done) state_next = ggu_pkg::S_SQ_Y;
      ggu_pkg::S_SQ_Y:   if (launched && status.done) state_next = ggu_pkg::S_SQRT;
      ggu_pkg::S_SQRT:
        if (launched && status.done) state_next = ggu_pkg::S_NORM_X;
      ggu_pkg::S_NORM_X:
        if (!status.norm) state_next = ggu_pkg::S_OUT;
        else if (launched && status.done) state_next = ggu_pkg::S_NORM_Y;
      ggu_pkg::S_NORM_Y: if (launched && status.done) state_next = ggu_pkg::S_OUT;
      ggu_pkg::S_OUT:    if (status.out_free) state_next = ggu_pkg::S_IDLE;
      default:           state_next = ggu_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.op       = ggu_pkg::OP_FACE_PX;
    in_ready     = 1'b0;
    case (state)
      ggu_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        cmd.take       = in_valid;
        cmd.cell_start = !in_cell;
      end
      ggu_pkg::S_PREV_X: cmd.op = ggu_pkg::OP_FACE_PX;
      ggu_pkg::S_PREV_Y: cmd.op = ggu_pkg::OP_FACE_PY;
      ggu_pkg::S_STORE:  cmd.store_prev = 1'b1;
      ggu_pkg::S_LAST_X: cmd.op = ggu_pkg::OP_FACE_LX;
      ggu_pkg::S_LAST_Y: cmd.op = ggu_pkg::OP_FACE_LY;
      ggu_pkg::S_DIV_X:  cmd.op = ggu_pkg::OP_DIV_X;
      ggu_pkg::S_DIV_Y:  cmd.op = ggu_pkg::OP_DIV_Y;
      ggu_pkg::S_SQ_X:   cmd.op = ggu_pkg::OP_SQ_X;
      ggu_pkg::S_SQ_Y:   cmd.op = ggu_pkg::OP_SQ_Y;
      ggu_pkg::S_SQRT:   cmd.op = ggu_pkg::OP_SQRT;
      ggu_pkg::S_NORM_X: cmd.op = ggu_pkg::OP_NORM_X;
      ggu_pkg::S_NORM_Y: cmd.op = ggu_pkg::OP_NORM_Y;
      ggu_pkg::S_OUT:    cmd.load_out = status.out_free;
      default:           cmd.op = ggu_pkg::OP_FACE_PX;
    endcase
    if (state != ggu_pkg::S_IDLE && state != ggu_pkg::S_STORE &&
        state != ggu_pkg::S_OUT && !(state == ggu_pkg::S_NORM_X && !status.norm)) begin
      cmd.start  = !launched;
      cmd.finish = launched && status.done;
    end
  end

endmodule

// ===== hw/rtl/ggu_datapath.sv =====
// datapath: face accumulators, serial multiplier, divider, square root, result register
module ggu_datapath (
  input  logic             clk,
  input  logic             rst,
  input  ggu_pkg::cmd_t    cmd,
  output ggu_pkg::status_t status,
  input  logic [127:0]     in_data,
  input  logic             in_flip,
  input  logic             cfg_valid,
  input  logic [ggu_pkg::THR_BITS-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [39:0]      out_data,
  output logic [1:0]       out_user
);

  logic [ggu_pkg::THR_BITS-1:0] thr;
  logic signed [31:0] iv, first_v, prev_v;
  logic signed [32:0] inx, iny, prev_nx, prev_ny;
  logic [30:0] ivol;
  logic signed [63:0] sum_x, sum_y;
  logic sat_seen;

  ggu_pkg::op_t op_r;
  logic [ggu_pkg::CNT_BITS-1:0] cnt;
  logic [65:0] prod, mcand;
  logic [32:0] mplier;
  logic        neg;
  logic [32:0] rem, dvs;
  logic [30:0] qs;
  logic        div_sat;
  logic [63:0] sx, sr;
  logic [62:0] sb;
  logic [30:0] mx, my;
  logic [61:0] sq_x, sq_y;
  logic [31:0] len;
  logic [15:0] qx, qy;

  // face operand select
  logic signed [32:0] f_n, f_s;
  logic [32:0] f_nm, f_sm;
  always_comb begin
    case (cmd.op)
      ggu_pkg::OP_FACE_PX: f_n = prev_nx;
      ggu_pkg::OP_FACE_PY: f_n = prev_ny;
      ggu_pkg::OP_FACE_LX: f_n = inx;
      default:             f_n = iny;
    endcase
    if (cmd.op == ggu_pkg::OP_FACE_PX || cmd.op == ggu_pkg::OP_FACE_PY)
      f_s = 33'(prev_v) + 33'(iv);
    else
      f_s = 33'(iv) + 33'(first_v);
    f_nm = f_n[32] ? 33'(-f_n) : f_n;
    f_sm = f_s[32] ? 33'(-f_s) : f_s;
  end

  // scaling divide setup
  logic [63:0] dm;
  logic [32:0] dd;
  logic        dsat;
  always_comb begin
    logic signed [63:0] ds;
    ds   = (cmd.op == ggu_pkg::OP_DIV_X) ? sum_x : sum_y;
    dm   = ds[63] ? 64'(-ds) : ds;
    dd   = {(ivol == '0) ? 31'd1 : ivol, 1'b0};
    dsat = dm >= {16'd0, dd, 15'd0};
  end

  // face term accumulate with saturation
  logic signed [64:0] term, acc_sum;
  logic signed [63:0] acc_old, acc_new;
  logic               acc_sat;
  always_comb begin
    term    = neg ? -65'(prod[65:16]) : 65'(prod[65:16]);
    acc_old = (op_r == ggu_pkg::OP_FACE_PX || op_r == ggu_pkg::OP_FACE_LX) ? sum_x : sum_y;
    acc_sum = 65'(acc_old) + term;
    acc_sat = acc_sum[64] != acc_sum[63];
    if (acc_sat) acc_new = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else acc_new = acc_sum[63:0];
  end

  // serial step values
  logic [33:0] rem2;
  logic [63:0] st;
  always_comb begin
    rem2 = {rem, qs[30]};
    st   = sr + 64'(sb);
  end

  logic norm_c;
  assign norm_c = {15'd0, len} > 47'(thr);
  assign status.norm     = norm_c;
  assign status.done     = cnt == '0;
  assign status.out_free = !out_valid || out_ready;

  // non-normalized component to Q1.15
  function automatic logic [16:0] q15(input logic [30:0] m);
    logic [29:0] s;
    s = m[30:1];
    return (s > 30'd32768) ? 17'd32768 : 17'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= ggu_pkg::THR_BITS'(1);
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) thr <= cfg_data;
      out_valid <= cmd.load_out || (out_valid && !out_ready);
      if (cmd.start) begin
        case (cmd.op)
          ggu_pkg::OP_FACE_PX, ggu_pkg::OP_FACE_PY, ggu_pkg::OP_FACE_LX,
          ggu_pkg::OP_FACE_LY, ggu_pkg::OP_SQ_X, ggu_pkg::OP_SQ_Y:
            cnt <= ggu_pkg::CNT_BITS'(ggu_pkg::MUL_STEPS);
          ggu_pkg::OP_DIV_X, ggu_pkg::OP_DIV_Y:
            cnt <= dsat ? '0 : ggu_pkg::CNT_BITS'(ggu_pkg::SCALE_STEPS);
          ggu_pkg::OP_SQRT: cnt <= ggu_pkg::CNT_BITS'(ggu_pkg::SQRT_STEPS);
          default:          cnt <= ggu_pkg::CNT_BITS'(ggu_pkg::NORM_STEPS);
        endcase
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      iv   <= in_data[31:0];
      inx  <= in_flip ? -33'($signed(in_data[63:32])) : 33'($signed(in_data[63:32]));
      iny  <= in_flip ? -33'($signed(in_data[95:64])) : 33'($signed(in_data[95:64]));
      ivol <= in_data[126:96];
      if (cmd.cell_start) begin
        first_v  <= in_data[31:0];
        sum_x    <= '0;
        sum_y    <= '0;
        sat_seen <= 1'b0;
      end
    end
    if (cmd.store_prev) begin
      prev_v  <= iv;
      prev_nx <= inx;
      prev_ny <= iny;
    end
    if (cmd.start) begin
      op_r <= cmd.op;
      prod <= '0;
      case (cmd.op)
        ggu_pkg::OP_FACE_PX, ggu_pkg::OP_FACE_PY, ggu_pkg::OP_FACE_LX,
        ggu_pkg::OP_FACE_LY: begin
          mcand  <= 66'(f_nm);
          mplier <= f_sm;
          neg    <= f_n[32] ^ f_s[32];
        end
        ggu_pkg::OP_SQ_X: begin
          mcand  <= 66'(mx);
          mplier <= 33'(mx);
        end
        ggu_pkg::OP_SQ_Y: begin
          mcand  <= 66'(my);
          mplier <= 33'(my);
        end
        ggu_pkg::OP_DIV_X, ggu_pkg::OP_DIV_Y: begin
          rem     <= dm[47:15];
          qs      <= {dm[14:0], 16'd0};
          dvs     <= dd;
          div_sat <= dsat;
        end
        ggu_pkg::OP_SQRT: begin
          sx <= 64'(sq_x) + 64'(sq_y);
          sr <= '0;
          sb <= {1'b1, 62'd0};
        end
        ggu_pkg::OP_NORM_X: begin
          rem <= 33'(mx[30:1]);
          qs  <= {mx[0], 30'd0};
          dvs <= 33'(len);
        end
        default: begin
          rem <= 33'(my[30:1]);
          qs  <= {my[0], 30'd0};
          dvs <= 33'(len);
        end
      endcase
    end else if (cnt != '0) begin
      case (op_r)
        ggu_pkg::OP_DIV_X, ggu_pkg::OP_DIV_Y, ggu_pkg::OP_NORM_X, ggu_pkg::OP_NORM_Y:
          if (rem2 >= {1'b0, dvs}) begin
            rem <= 33'(rem2 - {1'b0, dvs});
            qs  <= {qs[29:0], 1'b1};
          end else begin
            rem <= rem2[32:0];
            qs  <= {qs[29:0], 1'b0};
          end
        ggu_pkg::OP_SQRT: begin
          if (sx >= st) begin
            sx <= sx - st;
            sr <= (sr >> 1) + 64'(sb);
          end else begin
            sr <= sr >> 1;
          end
          sb <= sb >> 2;
        end
        default: begin
          prod   <= prod + mcand * 66'(mplier[3:0]);
          mcand  <= mcand << 4;
          mplier <= mplier >> 4;
        end
      endcase
    end
    if (cmd.finish) begin
      case (op_r)
        ggu_pkg::OP_FACE_PX, ggu_pkg::OP_FACE_LX: begin
          sum_x <= acc_new;
          if (acc_sat) sat_seen <= 1'b1;
        end
        ggu_pkg::OP_FACE_PY, ggu_pkg::OP_FACE_LY: begin
          sum_y <= acc_new;
          if (acc_sat) sat_seen <= 1'b1;
        end
        ggu_pkg::OP_DIV_X: begin
          mx <= div_sat ? {31{1'b1}} : qs;
          if (div_sat) sat_seen <= 1'b1;
        end
        ggu_pkg::OP_DIV_Y: begin
          my <= div_sat ? {31{1'b1}} : qs;
          if (div_sat) sat_seen <= 1'b1;
        end
        ggu_pkg::OP_SQ_X:   sq_x <= prod[61:0];
        ggu_pkg::OP_SQ_Y:   sq_y <= prod[61:0];
        ggu_pkg::OP_SQRT:   len  <= sr[31:0];
        ggu_pkg::OP_NORM_X: qx   <= qs[15:0];
        default:            qy   <= qs[15:0];
      endcase
    end
    if (cmd.load_out) begin
      logic [16:0] ox, oy;
      ox = norm_c ? 17'(qx) : q15(mx);
      oy = norm_c ? 17'(qy) : q15(my);
      out_data <= {6'd0, sum_y[63] ? 17'(-oy) : oy, sum_x[63] ? 17'(-ox) : ox};
      out_user <= {sat_seen, norm_c};
    end
  end

endmodule

// ===== hw/rtl/green_gauss_unit_gradient.sv =====
// top level: green-gauss unit gradient of one scalar over a 2d polygonal cell
//
// input stream: one item per node of a cell; the node value, the normal of the
// face from this node to the next and the cell volume travel in s_tdata,
// flip_normal in s_tuser and last_node in s_tlast. the item with s_tlast high
// closes the polygon back to the cell's first node and yields one result item.
// output stream: the gradient in q1.15 plus normalized and saturated flags.
// config channel: cfg_data writes norm_threshold (q1.16), reset value 1;
// write it only while the block is idle.
// sequence: an item that opens a cell is accepted and then stored; any later
// item is accepted, then runs two face multiplies (start, 9 serial steps of 4
// bits, finish) and a store step. no new item is taken until that is done.
// after the last item come two face multiplies, two scaling divides (cut short
// when saturating), two squares, a square root and, when normalizing, two
// divides; then the result register loads. one multiplier serves the face
// multiplies and the squares, and one divider serves both kinds of divide.
// reset clears the controller and the output valid and sets the threshold to 1;
// a stalled receiver holds the result register, and the block finishes the next
// cell up to the point of loading its result before it waits.
module green_gauss_unit_gradient (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // node_value, normal_x, normal_y, cell_volume, zero pad
  input  logic         s_tuser,   // flip_normal
  input  logic         s_tlast,   // last_node
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // grad_x, grad_y, zero pad
  output logic [1:0]   m_tuser,   // was_normalized, saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data   // norm_threshold
);

  ggu_pkg::cmd_t    cmd;
  ggu_pkg::status_t status;

  // config is always taken
  assign cfg_ready = 1'b1;

  ggu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ggu_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_flip   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

  // an accepted item never produces a result in the very next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid)))
    else $error("result appeared right after an input item");

  // grad_x stays within unit range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[16:0]) >= -17'sd32768) &&
                 ($signed(m_tdata[16:0]) <= 17'sd32768))
    else $error("grad_x out of range");

  // input is refused while a result is being formed
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken during cell back end");

endmodule
